// ===== rtl/lfid_pkg.sv =====
// Shared types and constants for the lowest-free identifier allocator.
// Used by every module under rtl but lfid_ram; no dependencies.
package lfid_pkg;

  localparam int MAX_IDS   = 8192;
  localparam int ID_W      = 16;                  // identifier width
  localparam int CNT_W     = 14;                  // count register width
  localparam int ID_AW     = $clog2(MAX_IDS);     // index bits
  localparam int WORD_W    = 32;                  // marks per memory word
  localparam int BIT_AW    = $clog2(WORD_W);
  localparam int NUM_WORDS = MAX_IDS / WORD_W;
  localparam int WORD_AW   = ID_AW - BIT_AW;
  localparam int GRP_W     = 16;                  // words per summary group
  localparam int GRP_AW    = $clog2(GRP_W);
  localparam int NUM_GRPS  = NUM_WORDS / GRP_W;
  localparam int NGRP_AW   = WORD_AW - GRP_AW;

  localparam logic [ID_W-1:0]  BASE_RST  = 16'd300;
  localparam logic [CNT_W-1:0] COUNT_RST = 14'd4701;

  // configuration register indexes
  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOT_USED = 2'd3;

  localparam logic [ID_W-1:0] ID_ZERO = '0;

  typedef struct packed {
    logic              found;
    logic [BIT_AW-1:0] idx;
  } ffz_res_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_GRP  = 7'b0000010,
    S_WRD  = 7'b0000100,
    S_BIT  = 7'b0001000,
    S_RCHK = 7'b0010000,
    S_RBIT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

endpackage

// ===== rtl/lfid_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module lfid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lfid_ffz.sv =====
// Shared find-first-zero unit: lowest clear bit of one memory-word-wide operand.
// Depends on lfid_pkg.
module lfid_ffz (
  input  logic [lfid_pkg::WORD_W-1:0] vec_i,
  output lfid_pkg::ffz_res_t          res_o
);

  always_comb begin
    res_o = '0;
    // scan downward so the lowest clear bit wins
    for (int i = lfid_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!vec_i[i]) begin
        res_o.found = 1'b1;
        res_o.idx   = lfid_pkg::BIT_AW'(i);
      end
    end
  end

endmodule

// ===== rtl/lowest_free_id_allocator_core.sv =====
// Lowest-free identifier allocator: sequencer, word summary and output register.
// Depends on lfid_pkg, lfid_ram and lfid_ffz.
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    mode_i, release_id_i
//  out      output     out_valid_o / out_stall_i  given_id_o, status_o
//  cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// Allocate: group pick, word pick plus memory read, bit pick plus write-back,
// result load. Release: range check, bit check, result load. A full memory or
// an out-of-range release skips to result load. One find-first-zero unit serves
// all picks; the mark memory has one read and one write port. Reset clears the
// word valid and full flags at once, so there is no clearing pass. The input
// opens after the result load; a stalled result holds the last step.
module lowest_free_id_allocator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         mode_i,
  input  logic [lfid_pkg::ID_W-1:0]    release_id_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lfid_pkg::ID_W-1:0]    given_id_o,
  output logic [1:0]                   status_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [lfid_pkg::ID_W-1:0]    cfg_wdata_i
);

  lfid_pkg::state_e state_q, state_d;

  logic [lfid_pkg::ID_W-1:0]      base_q;
  logic [lfid_pkg::CNT_W-1:0]     count_q;
  logic [lfid_pkg::CNT_W-1:0]     eff_n;

  logic [lfid_pkg::NUM_WORDS-1:0] word_full_q, word_full_d;
  logic [lfid_pkg::NUM_WORDS-1:0] word_vld_q, word_vld_d;
  logic [lfid_pkg::NUM_GRPS-1:0]  grp_full;

  logic [lfid_pkg::ID_W-1:0]      ridx_q, ridx_d;
  logic [lfid_pkg::NGRP_AW-1:0]   grp_q, grp_d;
  logic [lfid_pkg::GRP_AW-1:0]    wrd_q, wrd_d;
  logic                           rd_vld_q, rd_vld_d;

  logic                           out_valid_q, out_valid_d;
  logic [lfid_pkg::ID_W-1:0]      given_q, given_d, res_given_q, res_given_d;
  logic [1:0]                     status_q, status_d, res_status_q, res_status_d;

  logic [lfid_pkg::WORD_W-1:0]    ffz_vec;
  lfid_pkg::ffz_res_t             ffz_res;

  logic                           ram_we, ram_re;
  logic [lfid_pkg::WORD_AW-1:0]   ram_waddr, ram_raddr;
  logic [lfid_pkg::WORD_W-1:0]    ram_wdata, ram_rdata, rd_word;

  logic [lfid_pkg::ID_AW-1:0]     alloc_idx;
  logic [lfid_pkg::WORD_W-1:0]    bit_mask;
  logic                           in_acc, out_free;

  assign eff_n = (count_q > lfid_pkg::CNT_W'(lfid_pkg::MAX_IDS)) ?
                 lfid_pkg::CNT_W'(lfid_pkg::MAX_IDS) : count_q;

  always_comb begin
    for (int g = 0; g < lfid_pkg::NUM_GRPS; g++) begin
      grp_full[g] = &word_full_q[g*lfid_pkg::GRP_W +: lfid_pkg::GRP_W];
    end
  end

  // never-written words read as all free
  assign rd_word = rd_vld_q ? ram_rdata : '0;

  assign in_stall_o = (state_q != lfid_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    case (state_q)
      lfid_pkg::S_GRP:
        ffz_vec = {{(lfid_pkg::WORD_W - lfid_pkg::NUM_GRPS){1'b1}}, grp_full};
      lfid_pkg::S_WRD:
        ffz_vec = {{(lfid_pkg::WORD_W - lfid_pkg::GRP_W){1'b1}},
                   word_full_q[grp_q*lfid_pkg::GRP_W +: lfid_pkg::GRP_W]};
      default:
        ffz_vec = rd_word;
    endcase
  end

  lfid_ffz u_ffz (
    .vec_i (ffz_vec),
    .res_o (ffz_res)
  );

  lfid_ram #(
    .WIDTH (lfid_pkg::WORD_W),
    .DEPTH (lfid_pkg::NUM_WORDS)
  ) u_marks (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign alloc_idx = {grp_q, wrd_q, ffz_res.idx};
  assign bit_mask  = lfid_pkg::WORD_W'(1) << ridx_q[lfid_pkg::BIT_AW-1:0];

  always_comb begin
    state_d      = state_q;
    ridx_d       = ridx_q;
    grp_d        = grp_q;
    wrd_d        = wrd_q;
    rd_vld_d     = rd_vld_q;
    word_full_d  = word_full_q;
    word_vld_d   = word_vld_q;
    res_given_d  = res_given_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    given_d      = given_q;
    status_d     = status_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = ridx_q[lfid_pkg::ID_AW-1:lfid_pkg::BIT_AW];
    ram_wdata    = rd_word & ~bit_mask;
    ram_raddr    = ridx_q[lfid_pkg::ID_AW-1:lfid_pkg::BIT_AW];

    case (state_q)
      lfid_pkg::S_IDLE: begin
        if (in_acc) begin
          ridx_d  = release_id_i - base_q;
          state_d = mode_i ? lfid_pkg::S_RCHK : lfid_pkg::S_GRP;
        end
      end
      lfid_pkg::S_GRP: begin
        grp_d = ffz_res.idx[lfid_pkg::NGRP_AW-1:0];
        if (ffz_res.found) begin
          state_d = lfid_pkg::S_WRD;
        end else begin
          res_given_d  = lfid_pkg::ID_ZERO;
          res_status_d = lfid_pkg::ST_FULL;
          state_d      = lfid_pkg::S_DONE;
        end
      end
      lfid_pkg::S_WRD: begin
        wrd_d     = ffz_res.idx[lfid_pkg::GRP_AW-1:0];
        ram_raddr = {grp_q, ffz_res.idx[lfid_pkg::GRP_AW-1:0]};
        ram_re    = 1'b1;
        rd_vld_d  = word_vld_q[ram_raddr];
        state_d   = lfid_pkg::S_BIT;
      end
      lfid_pkg::S_BIT: begin
        // lowest free mark at or beyond the count means nothing below it is free
        if (ffz_res.found && ({1'b0, alloc_idx} < eff_n)) begin
          ram_waddr              = {grp_q, wrd_q};
          ram_wdata              = rd_word | (lfid_pkg::WORD_W'(1) << ffz_res.idx);
          ram_we                 = 1'b1;
          word_vld_d[ram_waddr]  = 1'b1;
          word_full_d[ram_waddr] = &ram_wdata;
          res_given_d            = base_q + lfid_pkg::ID_W'(alloc_idx);
          res_status_d           = lfid_pkg::ST_OK;
        end else begin
          res_given_d  = lfid_pkg::ID_ZERO;
          res_status_d = lfid_pkg::ST_FULL;
        end
        state_d = lfid_pkg::S_DONE;
      end
      lfid_pkg::S_RCHK: begin
        res_given_d = lfid_pkg::ID_ZERO;
        if (ridx_q >= lfid_pkg::ID_W'(eff_n)) begin
          res_status_d = lfid_pkg::ST_RANGE;
          state_d      = lfid_pkg::S_DONE;
        end else begin
          ram_re   = 1'b1;
          rd_vld_d = word_vld_q[ram_raddr];
          state_d  = lfid_pkg::S_RBIT;
        end
      end
      lfid_pkg::S_RBIT: begin
        if (rd_word[ridx_q[lfid_pkg::BIT_AW-1:0]]) begin
          ram_we                 = 1'b1;
          word_vld_d[ram_waddr]  = 1'b1;
          word_full_d[ram_waddr] = 1'b0;
          res_status_d           = lfid_pkg::ST_OK;
        end else begin
          res_status_d = lfid_pkg::ST_NOT_USED;
        end
        state_d = lfid_pkg::S_DONE;
      end
      lfid_pkg::S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          given_d     = res_given_q;
          status_d    = res_status_q;
          state_d     = lfid_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lfid_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfid_pkg::S_IDLE;
      word_full_q <= '0;
      word_vld_q  <= '0;
      out_valid_q <= 1'b0;
      base_q      <= lfid_pkg::BASE_RST;
      count_q     <= lfid_pkg::COUNT_RST;
    end else begin
      state_q     <= state_d;
      word_full_q <= word_full_d;
      word_vld_q  <= word_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lfid_pkg::CFG_BASE:  base_q  <= cfg_wdata_i;
          lfid_pkg::CFG_COUNT: count_q <= cfg_wdata_i[lfid_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q       <= ridx_d;
    grp_q        <= grp_d;
    wrd_q        <= wrd_d;
    rd_vld_q     <= rd_vld_d;
    res_given_q  <= res_given_d;
    res_status_q <= res_status_d;
    given_q      <= given_d;
    status_q     <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign given_id_o  = given_q;
  assign status_o    = status_q;

endmodule

// ===== rtl/lfid_checker.sv =====
// Port-level checks for the allocator core, bound to the allocator core.
// Depends on lfid_pkg and lowest_free_id_allocator_core.
module lfid_port_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [lfid_pkg::ID_W-1:0] given_id_o,
  input logic [1:0]                status_o
);

  // an accepted item keeps the input closed in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after an accepted item");

  // a failed request never carries an identifier
  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != lfid_pkg::ST_OK) |-> given_id_o == lfid_pkg::ID_ZERO)
    else $error("nonzero identifier on a failed request");

  // a result does not appear without a request accepted before it
  a_no_result_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised while the block was idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(given_id_o) && $stable(status_o))
    else $error("stalled result changed");

endmodule

bind lowest_free_id_allocator_core lfid_port_checker u_lfid_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .given_id_o  (given_id_o),
  .status_o    (status_o)
);
